FILE: design/bda_pkg.sv
// Shared types, codes and constants of the business day adjuster.
`default_nettype none

package bda_pkg;

    localparam int DAY_W = 24;
    localparam int SLOT_W = 10;
    localparam int CONV_W = 3;
    localparam int COUNT_W = 11;
    localparam int WALK_W = 26;
    localparam int KEY_W = 24;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ADJUST = 1'b1;

    localparam logic [CONV_W-1:0] CONV_FOLLOW = 3'd0;
    localparam logic [CONV_W-1:0] CONV_PRECEDE = 3'd1;
    localparam logic [CONV_W-1:0] CONV_MOD_FOLLOW = 3'd2;
    localparam logic [CONV_W-1:0] CONV_MOD_PRECEDE = 3'd3;
    localparam logic [CONV_W-1:0] CONV_NEAREST = 3'd4;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_SKIP = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;
    localparam logic [1:0] KIND_PASS = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic signed [DAY_W-1:0] day;
        logic [CONV_W-1:0] conv;
    } req_t;

endpackage

`default_nettype wire

FILE: design/bda_front.sv
// Request intake: classifies each request and holds it in a two-entry queue.
`default_nettype none

module bda_front #(
    parameter int TABLE_DEPTH = bda_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              cmd,
    input  wire logic [bda_pkg::SLOT_W-1:0]        slot,
    input  wire logic signed [bda_pkg::DAY_W-1:0]  day,
    input  wire logic [bda_pkg::CONV_W-1:0]        convention,
    output logic                                   busy,
    output logic                                   q_valid,
    output bda_pkg::req_t                          q_head,
    input  wire logic                              q_pop
);

    bda_pkg::req_t ent_reg [2];
    bda_pkg::req_t new_req;
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push;
    logic pop;

    always_comb
    begin
        new_req.slot = slot;
        new_req.day = day;
        new_req.conv = convention;
        if (cmd == bda_pkg::CMD_LOAD)
        begin
            new_req.kind = (32'(slot) < TABLE_DEPTH) ? bda_pkg::KIND_LOAD : bda_pkg::KIND_SKIP;
        end
        else
        begin
            new_req.kind = (convention <= bda_pkg::CONV_NEAREST) ? bda_pkg::KIND_SEARCH
                                                                  : bda_pkg::KIND_PASS;
        end
    end

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_pop && q_valid;
    assign q_head = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= new_req;
        end
    end

endmodule

`default_nettype wire

FILE: design/bda_month.sv
// Calendar unit: turns a day number into year * 12 + month with reciprocal multiplications.
`default_nettype none

module bda_month (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [bda_pkg::WALK_W-1:0]  day,
    output logic                                    done,
    output logic signed [bda_pkg::KEY_W-1:0]        key
);

    localparam int LAST = 12;

    localparam logic [63:0] ONE = 64'd1;
    localparam logic [27:0] M_ERA = 28'(((ONE << 45) + 64'd146096) / 64'd146097);
    localparam logic [18:0] M_A = 19'(((ONE << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M_B = 19'(((ONE << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] M_YOE = 19'(((ONE << 27) + 64'd364) / 64'd365);
    localparam logic [9:0] M_E = 10'(((ONE << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] M_MP = 12'(((ONE << 19) + 64'd152) / 64'd153);

    localparam logic signed [27:0] CIVIL_OFFSET = 28'sd38120300;

    logic [LAST:0] vld_reg, vld_next;
    logic signed [bda_pkg::WALK_W-1:0] day_reg, day_next;
    logic [26:0] zs_reg, zs_next;
    logic [9:0] eraq_reg, eraq_next;
    logic [17:0] doe_reg, doe_next;
    logic [6:0] a_reg, a_next;
    logic [2:0] b_reg, b_next;
    logic c_reg, c_next;
    logic [17:0] t_reg, t_next;
    logic [8:0] yoe_reg, yoe_next;
    logic [1:0] e_reg, e_next;
    logic [8:0] doy_reg, doy_next;
    logic [10:0] mpin_reg, mpin_next;
    logic [3:0] mp_reg, mp_next;
    logic [3:0] m_reg, m_next;
    logic signed [19:0] y_reg, y_next;
    logic signed [bda_pkg::KEY_W-1:0] key_reg, key_next;

    logic signed [27:0] zs_full;
    logic [54:0] prod_era;
    logic [26:0] doe_full;
    logic [36:0] prod_a;
    logic [36:0] prod_b;
    logic [36:0] prod_yoe;
    logic [18:0] prod_e;
    logic [18:0] yd;
    logic [18:0] doy_full;
    logic [22:0] prod_mp;
    logic signed [9:0] era;

    always_comb
    begin
        vld_next = {vld_reg[LAST-1:0], start};
        day_next = start ? day : day_reg;
        zs_full = 28'(day_reg) + CIVIL_OFFSET;
        zs_next = zs_full[26:0];
        prod_era = 55'(zs_reg) * 55'(M_ERA);
        eraq_next = prod_era[54:45];
        doe_full = zs_reg - 27'(eraq_reg) * 27'd146097;
        doe_next = doe_full[17:0];
        prod_a = 37'(doe_reg) * 37'(M_A);
        a_next = prod_a[35:29];
        prod_b = 37'(doe_reg) * 37'(M_B);
        b_next = prod_b[36:34];
        c_next = (doe_reg == 18'd146096);
        t_next = doe_reg - 18'(a_reg) + 18'(b_reg) - 18'(c_reg);
        prod_yoe = 37'(t_reg) * 37'(M_YOE);
        yoe_next = prod_yoe[35:27];
        prod_e = 19'(yoe_reg) * 19'(M_E);
        e_next = prod_e[17:16];
        yd = 19'(yoe_reg) * 19'd365 + 19'(yoe_reg >> 2) - 19'(e_reg);
        doy_full = 19'(doe_reg) - yd;
        doy_next = doy_full[8:0];
        mpin_next = 11'(doy_reg) * 11'd5 + 11'd2;
        prod_mp = 23'(mpin_reg) * 23'(M_MP);
        mp_next = prod_mp[22:19];
        era = $signed(eraq_reg - 10'd256);
        m_next = (mp_reg < 4'd10) ? (mp_reg + 4'd3) : (mp_reg - 4'd9);
        y_next = 20'(era) * 20'sd400 + 20'({1'b0, yoe_reg})
               + ((mp_reg >= 4'd10) ? 20'sd1 : 20'sd0);
        key_next = 24'(y_reg) * 24'sd12 + 24'(m_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg <= day_next;
        zs_reg <= zs_next;
        eraq_reg <= eraq_next;
        doe_reg <= doe_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        t_reg <= t_next;
        yoe_reg <= yoe_next;
        e_reg <= e_next;
        doy_reg <= doy_next;
        mpin_reg <= mpin_next;
        mp_reg <= mp_next;
        m_reg <= m_next;
        y_reg <= y_next;
        key_reg <= key_next;
    end

    assign done = vld_reg[LAST];
    assign key = key_reg;

endmodule

`default_nettype wire

FILE: design/bda_back.sv
// Execution engine: event table, binary search, run walks and convention choice.
`default_nettype none

module bda_back #(
    parameter int TABLE_DEPTH = bda_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_valid,
    input  wire bda_pkg::req_t                     q_head,
    output logic                                   q_pop,
    input  wire logic [bda_pkg::COUNT_W-1:0]       event_count,
    output logic                                   done,
    output logic signed [bda_pkg::DAY_W-1:0]       adjusted_day
);

    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WW = bda_pkg::WALK_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH_RD = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_CHK_RD = 4'd3;
    localparam logic [3:0] S_CHK_CMP = 4'd4;
    localparam logic [3:0] S_FWD_RD = 4'd5;
    localparam logic [3:0] S_FWD_CMP = 4'd6;
    localparam logic [3:0] S_BWD_RD = 4'd7;
    localparam logic [3:0] S_BWD_CMP = 4'd8;
    localparam logic [3:0] S_DECIDE = 4'd9;
    localparam logic [3:0] S_MX_GO = 4'd10;
    localparam logic [3:0] S_MX_WAIT = 4'd11;
    localparam logic [3:0] S_MR_GO = 4'd12;
    localparam logic [3:0] S_MR_WAIT = 4'd13;

    logic signed [bda_pkg::DAY_W-1:0] table_mem [TABLE_DEPTH];
    logic signed [bda_pkg::DAY_W-1:0] rdata_reg;

    logic [3:0] state_reg, state_next;
    logic [bda_pkg::CONV_W-1:0] conv_reg, conv_next;
    logic signed [WW-1:0] x_reg, x_next;
    logic signed [WW-1:0] y_reg, y_next;
    logic signed [WW-1:0] f_reg, f_next;
    logic signed [WW-1:0] p_reg, p_next;
    logic [NW-1:0] lo_reg, lo_next;
    logic [NW-1:0] hi_reg, hi_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [NW-1:0] j_reg, j_next;
    logic signed [bda_pkg::KEY_W-1:0] kx_reg, kx_next;
    logic done_reg, done_next;
    logic signed [bda_pkg::DAY_W-1:0] adj_reg, adj_next;

    logic [NW-1:0] n_val;
    logic [NW:0] sum;
    logic [NW-1:0] mid;
    logic signed [WW-1:0] t_val;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic mem_we;
    logic out_en;
    logic signed [WW-1:0] out_val;
    logic signed [WW:0] df;
    logic signed [WW:0] dp;
    logic m_start;
    logic signed [WW-1:0] m_day;
    logic m_done;
    logic signed [bda_pkg::KEY_W-1:0] m_key;
    logic [31:0] slot_ext;
    logic [31:0] mid_ext;
    logic [31:0] lo_ext;
    logic [31:0] j_ext;

    bda_month u_month (
        .clk   (clk),
        .rst_n (rst_n),
        .start (m_start),
        .day   (m_day),
        .done  (m_done),
        .key   (m_key)
    );

    assign n_val = (32'(event_count) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(event_count);
    assign sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid = sum[NW:1];
    assign t_val = WW'(rdata_reg);
    assign df = {f_reg[WW-1], f_reg} - {x_reg[WW-1], x_reg};
    assign dp = {x_reg[WW-1], x_reg} - {p_reg[WW-1], p_reg};
    assign slot_ext = 32'(q_head.slot);
    assign mid_ext = 32'(mid);
    assign lo_ext = 32'(lo_reg);
    assign j_ext = 32'(j_reg);
    assign waddr = slot_ext[AW-1:0];
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign mem_we = q_pop && (q_head.kind == bda_pkg::KIND_LOAD);
    assign m_start = (state_reg == S_MX_GO) || (state_reg == S_MR_GO);
    assign m_day = (state_reg == S_MX_GO) ? x_reg
                 : ((conv_reg == bda_pkg::CONV_MOD_FOLLOW) ? f_reg : p_reg);

    always_comb
    begin
        case (state_reg)
            S_SRCH_RD: raddr = mid_ext[AW-1:0];
            S_CHK_RD: raddr = lo_ext[AW-1:0];
            S_FWD_RD: raddr = j_ext[AW-1:0];
            S_BWD_RD: raddr = j_ext[AW-1:0];
            default: raddr = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        conv_next = conv_reg;
        x_next = x_reg;
        y_next = y_reg;
        f_next = f_reg;
        p_next = p_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        idx_next = idx_reg;
        j_next = j_reg;
        kx_next = kx_reg;
        out_en = 1'b0;
        out_val = x_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_head.kind)
                        bda_pkg::KIND_SEARCH:
                        begin
                            conv_next = q_head.conv;
                            x_next = WW'(q_head.day);
                            lo_next = '0;
                            hi_next = n_val;
                            state_next = S_SRCH_RD;
                        end
                        bda_pkg::KIND_PASS:
                        begin
                            out_en = 1'b1;
                            out_val = WW'(q_head.day);
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                state_next = (lo_reg < hi_reg) ? S_SRCH_CMP : S_CHK_RD;
            end
            S_SRCH_CMP:
            begin
                if (t_val < x_reg)
                begin
                    lo_next = mid + NW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SRCH_RD;
            end
            S_CHK_RD:
            begin
                if (lo_reg < n_val)
                begin
                    state_next = S_CHK_CMP;
                end
                else
                begin
                    out_en = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CHK_CMP:
            begin
                if (t_val == x_reg)
                begin
                    idx_next = lo_reg;
                    j_next = lo_reg;
                    y_next = x_reg;
                    state_next = S_FWD_RD;
                end
                else
                begin
                    out_en = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FWD_RD:
            begin
                if (j_reg == n_val)
                begin
                    f_next = y_reg;
                    j_next = idx_reg;
                    y_next = x_reg;
                    state_next = S_BWD_RD;
                end
                else
                begin
                    state_next = S_FWD_CMP;
                end
            end
            S_FWD_CMP:
            begin
                if (t_val == y_reg)
                begin
                    y_next = y_reg + WW'(1);
                    j_next = j_reg + NW'(1);
                    state_next = S_FWD_RD;
                end
                else
                begin
                    f_next = y_reg;
                    j_next = idx_reg;
                    y_next = x_reg;
                    state_next = S_BWD_RD;
                end
            end
            S_BWD_RD:
            begin
                state_next = S_BWD_CMP;
            end
            S_BWD_CMP:
            begin
                if (t_val == y_reg)
                begin
                    y_next = y_reg - WW'(1);
                    if (j_reg == '0)
                    begin
                        p_next = y_reg - WW'(1);
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        j_next = j_reg - NW'(1);
                        state_next = S_BWD_RD;
                    end
                end
                else
                begin
                    p_next = y_reg;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                case (conv_reg)
                    bda_pkg::CONV_FOLLOW:
                    begin
                        out_en = 1'b1;
                        out_val = f_reg;
                    end
                    bda_pkg::CONV_PRECEDE:
                    begin
                        out_en = 1'b1;
                        out_val = p_reg;
                    end
                    bda_pkg::CONV_NEAREST:
                    begin
                        out_en = 1'b1;
                        out_val = (df <= dp) ? f_reg : p_reg;
                    end
                    bda_pkg::CONV_MOD_FOLLOW, bda_pkg::CONV_MOD_PRECEDE:
                    begin
                        state_next = S_MX_GO;
                    end
                    default:
                    begin
                        out_en = 1'b1;
                    end
                endcase
            end
            S_MX_GO:
            begin
                state_next = S_MX_WAIT;
            end
            S_MX_WAIT:
            begin
                if (m_done)
                begin
                    kx_next = m_key;
                    state_next = S_MR_GO;
                end
            end
            S_MR_GO:
            begin
                state_next = S_MR_WAIT;
            end
            S_MR_WAIT:
            begin
                if (m_done)
                begin
                    out_en = 1'b1;
                    state_next = S_IDLE;
                    if (conv_reg == bda_pkg::CONV_MOD_FOLLOW)
                    begin
                        out_val = (m_key == kx_reg) ? f_reg : p_reg;
                    end
                    else
                    begin
                        out_val = (m_key == kx_reg) ? p_reg : f_reg;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        done_next = out_en;
        adj_next = out_en ? out_val[bda_pkg::DAY_W-1:0] : adj_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            adj_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            adj_reg <= adj_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conv_reg <= conv_next;
        x_reg <= x_next;
        y_reg <= y_next;
        f_reg <= f_next;
        p_reg <= p_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        idx_reg <= idx_next;
        j_reg <= j_next;
        kx_reg <= kx_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[waddr] <= q_head.day;
        end
        rdata_reg <= table_mem[raddr];
    end

    assign done = done_reg;
    assign adjusted_day = adj_reg;

endmodule

`default_nettype wire

FILE: design/business_day_adjuster_core.sv
// Top level of the business day adjuster: request queue, engine and count register.
`default_nettype none

// Requests enter when start is high and busy is low; a two-request queue sits
// in front of the engine, so busy is high only while that queue is full. A
// table load gives no result. A query runs a binary search in which each probe
// reads the table and then compares, then walks the run of consecutive event
// days forward and backward, one table read and one compare per event day. The
// modified conventions add two calendar conversions in the calendar unit.
// A day that is not an event comes back after the search alone; an unknown
// convention comes back without a search. Each result appears on adjusted_day
// with done high for exactly one cycle and stays there until the next result;
// the receiver cannot stall the block, and results come in request order.
module business_day_adjuster_core #(
    parameter int TABLE_DEPTH = bda_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              cmd,
    input  wire logic [bda_pkg::SLOT_W-1:0]        slot,
    input  wire logic signed [bda_pkg::DAY_W-1:0]  day,
    input  wire logic [bda_pkg::CONV_W-1:0]        convention,
    input  wire logic                              event_count_we,
    input  wire logic [bda_pkg::COUNT_W-1:0]       event_count,
    output logic                                   done,
    output logic signed [bda_pkg::DAY_W-1:0]       adjusted_day
);

    logic [bda_pkg::COUNT_W-1:0] count_reg, count_next;
    logic q_valid;
    logic q_pop;
    bda_pkg::req_t q_head;

    assign count_next = event_count_we ? event_count : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    bda_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .slot       (slot),
        .day        (day),
        .convention (convention),
        .busy       (busy),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop)
    );

    bda_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .event_count  (count_reg),
        .done         (done),
        .adjusted_day (adjusted_day)
    );

endmodule

`default_nettype wire

FILE: design/bda_checker.sv
// Port-level checks of the business day adjuster and their bind to the top level.
`default_nettype none

module bda_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              done,
    input wire logic signed [bda_pkg::DAY_W-1:0]  adjusted_day
);

    // The queue only fills up when a request was taken in the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted request");

    // With no request taken, a queue that has room cannot become full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !busy)
        else $error("busy rose while no request was offered");

    // The result value only changes together with the done strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(adjusted_day) |-> done)
        else $error("adjusted_day changed without done");

endmodule

bind business_day_adjuster_core bda_checker u_bda_checker (.*);

`default_nettype wire
